[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at each rising edge of clk_i while rst_ni is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that cond is followed in the next cycle by nxt.
`define ASSERT_NEXT(label, cond, nxt, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error(msg);

`endif

[hdl/spte_pkg.sv]
// ----------------------------------------------------------------------------
// Sparse polynomial term engine package
// Sizes, codes and the command and status bundles shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package spte_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int MAX_TERMS = 16;

  localparam int MODEW = 3;
  localparam int SLOTW = 3;
  localparam int COEFW = 32;
  localparam int EXPW  = 8;
  localparam int STW   = 2;

  localparam int SIDXW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int IDXW  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNTW  = $clog2(MAX_TERMS + 1);
  localparam int ADDRW = (NUM_SLOTS * MAX_TERMS > 1) ? $clog2(NUM_SLOTS * MAX_TERMS) : 1;
  localparam int DEPTH = NUM_SLOTS * MAX_TERMS;

  localparam logic [MODEW-1:0] MODE_CLEAR = 3'd0;
  localparam logic [MODEW-1:0] MODE_ADD   = 3'd1;
  localparam logic [MODEW-1:0] MODE_SCALE = 3'd2;
  localparam logic [MODEW-1:0] MODE_EVAL  = 3'd3;
  localparam logic [MODEW-1:0] MODE_DIFF  = 3'd4;

  localparam logic [STW-1:0] ST_OK     = 2'd0;
  localparam logic [STW-1:0] ST_NOSLOT = 2'd1;
  localparam logic [STW-1:0] ST_FULL   = 2'd2;

  typedef enum logic [1:0] {
    WD_COPY,
    WD_SUM,
    WD_NEW,
    WD_PROD
  } wdata_e;

  typedef enum logic [1:0] {
    WI_WR,
    WI_RD,
    WI_RD1
  } widx_e;

  typedef enum logic {
    MUL_SCALE,
    MUL_EVAL
  } mul_e;

  typedef struct packed {
    logic           load;
    logic           rd_en;
    logic           rd_prev;
    logic           rd_inc;
    logic           rd_dec;
    logic           rd_to_n;
    logic           pos_cap;
    logic           wr_en;
    wdata_e         wr_data;
    widx_e          wr_idx;
    logic           wr_inc;
    logic           wr_from_rd;
    logic           cnt_clear;
    logic           cnt_inc;
    logic           cnt_set_wr;
    logic           mul_load;
    mul_e           mul_sel;
    logic           pw_init;
    logic           pw_step;
    logic           acc_add;
    logic           st_load;
    logic [STW-1:0] st;
    logic           out_load;
  } cmd_t;

  typedef struct packed {
    logic [MODEW-1:0] mode;
    logic             slot_in;
    logic             slot_ok;
    logic             tgt_ok;
    logic             rd_end;
    logic             rd_at_pos;
    logic             expo_gt;
    logic             expo_eq;
    logic             sum_zero;
    logic             val_zero;
    logic             full;
    logic             keep;
    logic             pw_done;
    logic             out_free;
  } sts_t;

  function automatic logic [ADDRW-1:0] term_addr(logic [SIDXW-1:0] s, logic [IDXW-1:0] i);
    return ADDRW'(s) * ADDRW'(MAX_TERMS) + ADDRW'(i);
  endfunction

endpackage

`default_nettype wire

[hdl/spte_if.sv]
// ----------------------------------------------------------------------------
// Sparse polynomial term engine channels
// Command and result channels with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface spte_in_if;
  logic                               valid;
  logic                               ready;
  logic        [spte_pkg::MODEW-1:0] mode;
  logic        [spte_pkg::SLOTW-1:0] slot;
  logic signed [spte_pkg::COEFW-1:0] value;
  logic        [spte_pkg::EXPW-1:0]  exponent;
  logic        [spte_pkg::SLOTW-1:0] target_slot;

  modport source (output valid, mode, slot, value, exponent, target_slot, input ready);
  modport sink (input valid, mode, slot, value, exponent, target_slot, output ready);
endinterface

interface spte_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [spte_pkg::COEFW-1:0] result;
  logic        [spte_pkg::STW-1:0]   status;

  modport source (output valid, result, status, input ready);
  modport sink (input valid, result, status, output ready);
endinterface

`default_nettype wire

[hdl/spte_ctrl.sv]
// ----------------------------------------------------------------------------
// Sparse polynomial term engine controller
// Sequences the term walks of each command and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module spte_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire spte_pkg::sts_t  sts_i,
  output spte_pkg::cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_INS,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_SC_RD,
    S_SC_MUL,
    S_SC_WR,
    S_EV_RD,
    S_EV_INIT,
    S_EV_PW,
    S_EV_ACC,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_DONE;
        case (sts_i.mode)
          spte_pkg::MODE_CLEAR: begin
            if (sts_i.slot_in) begin
              cmd_o.cnt_clear = 1'b1;
            end else begin
              cmd_o.st_load = 1'b1;
              cmd_o.st      = spte_pkg::ST_NOSLOT;
            end
          end
          spte_pkg::MODE_ADD, spte_pkg::MODE_SCALE, spte_pkg::MODE_EVAL,
          spte_pkg::MODE_DIFF: begin
            if (!sts_i.slot_ok || (sts_i.mode == spte_pkg::MODE_DIFF && !sts_i.tgt_ok)) begin
              cmd_o.st_load = 1'b1;
              cmd_o.st      = spte_pkg::ST_NOSLOT;
            end else if (sts_i.mode == spte_pkg::MODE_ADD) begin
              state_d = S_SRCH_RD;
            end else if (sts_i.mode == spte_pkg::MODE_EVAL) begin
              state_d = S_EV_RD;
            end else begin
              state_d = S_SC_RD;
            end
          end
          default: begin
          end
        endcase
      end
      S_SRCH_RD: begin
        if (sts_i.rd_end) begin
          state_d = S_DONE;
          if (sts_i.val_zero) begin
          end else if (sts_i.full) begin
            cmd_o.st_load = 1'b1;
            cmd_o.st      = spte_pkg::ST_FULL;
          end else begin
            cmd_o.pos_cap = 1'b1;
            cmd_o.rd_to_n = 1'b1;
            state_d       = S_INS;
          end
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_SRCH_CHK;
        end
      end
      S_SRCH_CHK: begin
        state_d = S_DONE;
        if (sts_i.expo_gt) begin
          cmd_o.rd_inc = 1'b1;
          state_d      = S_SRCH_RD;
        end else if (sts_i.expo_eq) begin
          if (sts_i.sum_zero) begin
            cmd_o.wr_from_rd = 1'b1;
            cmd_o.rd_inc     = 1'b1;
            state_d          = S_DEL_RD;
          end else begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_data = spte_pkg::WD_SUM;
            cmd_o.wr_idx  = spte_pkg::WI_RD;
          end
        end else if (sts_i.val_zero) begin
        end else if (sts_i.full) begin
          cmd_o.st_load = 1'b1;
          cmd_o.st      = spte_pkg::ST_FULL;
        end else begin
          cmd_o.pos_cap = 1'b1;
          cmd_o.rd_to_n = 1'b1;
          state_d       = S_INS;
        end
      end
      S_INS: begin
        if (sts_i.rd_at_pos) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_data = spte_pkg::WD_NEW;
          cmd_o.wr_idx  = spte_pkg::WI_RD;
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_DONE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_prev = 1'b1;
          cmd_o.rd_dec  = 1'b1;
          state_d       = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_data = spte_pkg::WD_COPY;
        cmd_o.wr_idx  = spte_pkg::WI_RD1;
        state_d       = S_INS;
      end
      S_DEL_RD: begin
        if (sts_i.rd_end) begin
          cmd_o.cnt_set_wr = 1'b1;
          state_d          = S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_data = spte_pkg::WD_COPY;
        cmd_o.wr_idx  = spte_pkg::WI_WR;
        cmd_o.wr_inc  = 1'b1;
        cmd_o.rd_inc  = 1'b1;
        state_d       = S_DEL_RD;
      end
      S_SC_RD: begin
        if (sts_i.rd_end) begin
          cmd_o.cnt_set_wr = 1'b1;
          state_d          = S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_SC_MUL;
        end
      end
      S_SC_MUL: begin
        cmd_o.mul_load = 1'b1;
        cmd_o.mul_sel  = spte_pkg::MUL_SCALE;
        cmd_o.rd_inc   = 1'b1;
        state_d        = S_SC_WR;
      end
      S_SC_WR: begin
        if (sts_i.keep) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_data = spte_pkg::WD_PROD;
          cmd_o.wr_idx  = spte_pkg::WI_WR;
          cmd_o.wr_inc  = 1'b1;
        end
        state_d = S_SC_RD;
      end
      S_EV_RD: begin
        if (sts_i.rd_end) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_EV_INIT;
        end
      end
      S_EV_INIT: begin
        cmd_o.pw_init = 1'b1;
        cmd_o.rd_inc  = 1'b1;
        state_d       = S_EV_PW;
      end
      S_EV_PW: begin
        if (sts_i.pw_done) begin
          cmd_o.mul_load = 1'b1;
          cmd_o.mul_sel  = spte_pkg::MUL_EVAL;
          state_d        = S_EV_ACC;
        end else begin
          cmd_o.pw_step = 1'b1;
        end
      end
      S_EV_ACC: begin
        cmd_o.acc_add = 1'b1;
        state_d       = S_EV_RD;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hdl/spte_dp.sv]
// ----------------------------------------------------------------------------
// Sparse polynomial term engine datapath
// Term memory, slot counts, walk indexes, multiplier, power unit and output.
// ----------------------------------------------------------------------------
`default_nettype none

module spte_dp (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire spte_pkg::cmd_t                 cmd_i,
  output spte_pkg::sts_t                      sts_o,
  input  wire        [spte_pkg::MODEW-1:0]    in_mode_i,
  input  wire        [spte_pkg::SLOTW-1:0]    in_slot_i,
  input  wire        [spte_pkg::COEFW-1:0]    in_value_i,
  input  wire        [spte_pkg::EXPW-1:0]     in_exponent_i,
  input  wire        [spte_pkg::SLOTW-1:0]    in_target_slot_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output logic       [spte_pkg::COEFW-1:0]    out_result_o,
  output logic       [spte_pkg::STW-1:0]      out_status_o
);

  logic [spte_pkg::COEFW+spte_pkg::EXPW-1:0] mem [spte_pkg::DEPTH];

  logic [spte_pkg::CNTW-1:0] cnt_q [spte_pkg::NUM_SLOTS];
  logic [spte_pkg::NUM_SLOTS-1:0] vld_q;

  logic [spte_pkg::MODEW-1:0] mode_q;
  logic [spte_pkg::SLOTW-1:0] slot_q, tgt_q;
  logic [spte_pkg::COEFW-1:0] val_q;
  logic [spte_pkg::EXPW-1:0]  exp_q;

  logic [spte_pkg::CNTW-1:0]  n_q, rd_q, wr_q, pos_q;
  logic [spte_pkg::COEFW-1:0] rcoef_q, prod_q, acc_q, pw_r_q, pw_x_q;
  logic [spte_pkg::EXPW-1:0]  rexpo_q, pw_e_q;
  logic [spte_pkg::STW-1:0]   st_q;

  logic [spte_pkg::SIDXW-1:0] sidx, tidx, wsidx;
  logic [spte_pkg::CNTW-1:0]  rd_m1, rd_p1, widx_full;
  logic [spte_pkg::IDXW-1:0]  ridx, widx;
  logic [spte_pkg::COEFW-1:0] sum, mul_a, mul_b, wcoef;
  logic [spte_pkg::EXPW-1:0]  wexpo;
  logic                       is_diff;

  assign sidx    = spte_pkg::SIDXW'(slot_q);
  assign tidx    = spte_pkg::SIDXW'(tgt_q);
  assign is_diff = (mode_q == spte_pkg::MODE_DIFF);
  assign wsidx   = is_diff ? tidx : sidx;
  assign rd_m1   = rd_q - spte_pkg::CNTW'(1);
  assign rd_p1   = rd_q + spte_pkg::CNTW'(1);
  assign ridx    = cmd_i.rd_prev ? rd_m1[spte_pkg::IDXW-1:0] : rd_q[spte_pkg::IDXW-1:0];
  assign sum     = rcoef_q + val_q;

  always_comb begin
    case (cmd_i.wr_idx)
      spte_pkg::WI_RD:  widx_full = rd_q;
      spte_pkg::WI_RD1: widx_full = rd_p1;
      default:          widx_full = wr_q;
    endcase
  end
  assign widx = widx_full[spte_pkg::IDXW-1:0];

  always_comb begin
    case (cmd_i.wr_data)
      spte_pkg::WD_SUM: begin
        wcoef = sum;
        wexpo = rexpo_q;
      end
      spte_pkg::WD_NEW: begin
        wcoef = val_q;
        wexpo = exp_q;
      end
      spte_pkg::WD_PROD: begin
        wcoef = prod_q;
        wexpo = is_diff ? rexpo_q - spte_pkg::EXPW'(1) : rexpo_q;
      end
      default: begin
        wcoef = rcoef_q;
        wexpo = rexpo_q;
      end
    endcase
  end

  always_comb begin
    mul_a = rcoef_q;
    case (cmd_i.mul_sel)
      spte_pkg::MUL_EVAL: mul_b = pw_r_q;
      default:            mul_b = is_diff ? spte_pkg::COEFW'(rexpo_q) : val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[spte_pkg::term_addr(wsidx, widx)] <= {wcoef, wexpo};
    end
    if (cmd_i.rd_en) begin
      {rcoef_q, rexpo_q} <= mem[spte_pkg::term_addr(sidx, ridx)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= in_mode_i;
      slot_q <= in_slot_i;
      val_q  <= in_value_i;
      exp_q  <= in_exponent_i;
      tgt_q  <= in_target_slot_i;
      n_q    <= cnt_q[spte_pkg::SIDXW'(in_slot_i)];
      rd_q   <= '0;
      wr_q   <= '0;
      acc_q  <= '0;
      st_q   <= spte_pkg::ST_OK;
    end else begin
      if (cmd_i.rd_inc) begin
        rd_q <= rd_p1;
      end else if (cmd_i.rd_dec) begin
        rd_q <= rd_m1;
      end else if (cmd_i.rd_to_n) begin
        rd_q <= n_q;
      end
      if (cmd_i.wr_from_rd) begin
        wr_q <= rd_q;
      end else if (cmd_i.wr_inc) begin
        wr_q <= wr_q + spte_pkg::CNTW'(1);
      end
      if (cmd_i.acc_add) begin
        acc_q <= acc_q + prod_q;
      end
      if (cmd_i.st_load) begin
        st_q <= cmd_i.st;
      end
    end
    if (cmd_i.pos_cap) begin
      pos_q <= rd_q;
    end
    if (cmd_i.mul_load) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.pw_init) begin
      pw_r_q <= spte_pkg::COEFW'(1);
      pw_x_q <= val_q;
      pw_e_q <= rexpo_q;
    end else if (cmd_i.pw_step) begin
      if (pw_e_q[0]) begin
        pw_r_q <= pw_r_q * pw_x_q;
      end
      pw_x_q <= pw_x_q * pw_x_q;
      pw_e_q <= pw_e_q >> 1;
    end
    if (cmd_i.out_load) begin
      out_result_o <= (mode_q == spte_pkg::MODE_EVAL && st_q == spte_pkg::ST_OK) ? acc_q : '0;
      out_status_o <= st_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < spte_pkg::NUM_SLOTS; i++) begin
        cnt_q[i] <= '0;
      end
      vld_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.cnt_clear) begin
        cnt_q[sidx] <= '0;
        vld_q[sidx] <= 1'b1;
      end else if (cmd_i.cnt_inc) begin
        cnt_q[sidx] <= cnt_q[sidx] + spte_pkg::CNTW'(1);
      end else if (cmd_i.cnt_set_wr) begin
        cnt_q[wsidx] <= wr_q;
        vld_q[wsidx] <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.mode      = mode_q;
    sts_o.slot_in   = (32'(slot_q) < 32'(spte_pkg::NUM_SLOTS));
    sts_o.slot_ok   = sts_o.slot_in && vld_q[sidx];
    sts_o.tgt_ok    = (32'(tgt_q) < 32'(spte_pkg::NUM_SLOTS));
    sts_o.rd_end    = (rd_q >= n_q);
    sts_o.rd_at_pos = (rd_q == pos_q);
    sts_o.expo_gt   = (rexpo_q > exp_q);
    sts_o.expo_eq   = (rexpo_q == exp_q);
    sts_o.sum_zero  = (sum == '0);
    sts_o.val_zero  = (val_q == '0);
    sts_o.full      = (n_q >= spte_pkg::CNTW'(spte_pkg::MAX_TERMS));
    sts_o.keep      = (prod_q != '0) && !(is_diff && rexpo_q == '0);
    sts_o.pw_done   = (pw_e_q == '0);
    sts_o.out_free  = !out_valid_o || out_ready_i;
  end

endmodule

`default_nettype wire

[hdl/sparse_polynomial_term_engine.sv]
// ----------------------------------------------------------------------------
// Sparse polynomial term engine
// Holds NUM_SLOTS sparse integer polynomials and runs one command per item.
//
// Commands arrive on in_i and each produces exactly one transfer on out_o.
// in_i.ready is high only while the engine is idle; a command is taken on the
// edge where valid and ready are both high. Its result is written to an output
// register, so the next command is taken while that result still waits.
// Clear and rejected commands pass from the execute state straight to done. Add
// walks the terms with a read and a compare for each one passed in the search,
// then shifts terms up to insert or compacts them after a cancelled term; scale
// and differentiate read and multiply each stored term and write back each kept
// product; evaluate runs the square-and-multiply power unit over the exponent
// bits (up to 8) of each term.
// Reset clears the slot valid flags and term counts; no term memory is cleared.
// When out_o.ready stays low, the result is held and the engine stops before
// loading the following result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sparse_polynomial_term_engine (
  input  wire        clk_i,
  input  wire        rst_ni,
  spte_in_if.sink    in_i,
  spte_out_if.source out_o
);

  spte_pkg::cmd_t cmd;
  spte_pkg::sts_t sts;
  logic           in_ready;
  logic           out_valid;
  logic [spte_pkg::COEFW-1:0] out_result;
  logic [spte_pkg::STW-1:0]   out_status;

  spte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  spte_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .in_mode_i        (in_i.mode),
    .in_slot_i        (in_i.slot),
    .in_value_i       (in_i.value),
    .in_exponent_i    (in_i.exponent),
    .in_target_slot_i (in_i.target_slot),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_o.ready),
    .out_result_o     (out_result),
    .out_status_o     (out_status)
  );

  assign in_i.ready   = in_ready;
  assign out_o.valid  = out_valid;
  assign out_o.result = out_result;
  assign out_o.status = out_status;

  `ASSERT_NEXT(a_busy_after_accept, in_i.valid && in_i.ready, !in_i.ready,
               "engine took a command while another was in progress")
  `ASSERT_CLK(a_err_result_zero,
              !out_o.valid || out_o.status == spte_pkg::ST_OK || out_o.result == '0,
              "nonzero result reported with an error status")
  `ASSERT_NEXT(a_load_only_when_free, cmd.out_load && out_o.valid && !out_o.ready,
               1'b0, "output register overwritten while a result was stalled")

endmodule

`default_nettype wire

[verif/spte_poly_book.sv]
// ----------------------------------------------------------------------------
// Polynomial command scoreboard
// Tracks the slot contents and checks every result transfer in order.
// ----------------------------------------------------------------------------
`default_nettype none

package spte_tb_pkg;
  import spte_pkg::*;

  typedef struct packed {
    logic [COEFW-1:0] result;
    logic [STW-1:0]   status;
  } outcome_t;

  class poly_book;
    logic [COEFW-1:0] coef[NUM_SLOTS][MAX_TERMS];
    logic [EXPW-1:0]  expo[NUM_SLOTS][MAX_TERMS];
    int               count[NUM_SLOTS];
    bit               live[NUM_SLOTS];
    outcome_t         pending[$];
    int               errors;

    function new();
      errors = 0;
      foreach (count[s]) begin
        count[s] = 0;
        live[s] = 0;
      end
    endfunction

    function void drop(int s, int i);
      for (int k = i; k + 1 < count[s]; k++) begin
        coef[s][k] = coef[s][k+1];
        expo[s][k] = expo[s][k+1];
      end
      count[s]--;
    endfunction

    function logic [STW-1:0] insert(int s, logic [COEFW-1:0] c, logic [EXPW-1:0] e);
      int i;
      logic [COEFW-1:0] sum;
      i = 0;
      while (i < count[s] && expo[s][i] > e) i++;
      if (i < count[s] && expo[s][i] == e) begin
        sum = coef[s][i] + c;
        if (sum == 0) drop(s, i);
        else coef[s][i] = sum;
        return ST_OK;
      end
      if (c == 0) return ST_OK;
      if (count[s] >= MAX_TERMS) return ST_FULL;
      for (int k = count[s]; k > i; k--) begin
        coef[s][k] = coef[s][k-1];
        expo[s][k] = expo[s][k-1];
      end
      coef[s][i] = c;
      expo[s][i] = e;
      count[s]++;
      return ST_OK;
    endfunction

    function logic [COEFW-1:0] evaluate(int s, logic [COEFW-1:0] x);
      logic [COEFW-1:0] acc, p, b;
      logic [EXPW-1:0] e;
      acc = 0;
      for (int i = 0; i < count[s]; i++) begin
        p = 1;
        b = x;
        e = expo[s][i];
        while (e != 0) begin
          if (e[0]) p = p * b;
          b = b * b;
          e = e >> 1;
        end
        acc = acc + coef[s][i] * p;
      end
      return acc;
    endfunction

    function void note_command(logic [MODEW-1:0] mode, int s, logic [COEFW-1:0] v,
                               logic [EXPW-1:0] e, int t);
      outcome_t o;
      logic [COEFW-1:0] nc[MAX_TERMS], p;
      logic [EXPW-1:0]  ne[MAX_TERMS];
      int m, i;
      o = '0;
      case (mode)
        MODE_CLEAR: begin
          live[s] = 1;
          count[s] = 0;
        end
        MODE_ADD: o.status = live[s] ? insert(s, v, e) : ST_NOSLOT;
        MODE_SCALE: begin
          if (!live[s]) o.status = ST_NOSLOT;
          else begin
            i = 0;
            while (i < count[s]) begin
              p = coef[s][i] * v;
              if (p == 0) drop(s, i);
              else begin
                coef[s][i] = p;
                i++;
              end
            end
          end
        end
        MODE_EVAL: begin
          if (live[s]) o.result = evaluate(s, v);
          else o.status = ST_NOSLOT;
        end
        MODE_DIFF: begin
          if (!live[s]) o.status = ST_NOSLOT;
          else begin
            m = 0;
            for (int k = 0; k < count[s]; k++) begin
              p = coef[s][k] * COEFW'(expo[s][k]);
              if (expo[s][k] != 0 && p != 0) begin
                nc[m] = p;
                ne[m] = expo[s][k] - 1;
                m++;
              end
            end
            for (int k = 0; k < m; k++) begin
              coef[t][k] = nc[k];
              expo[t][k] = ne[k];
            end
            count[t] = m;
            live[t] = 1;
          end
        end
        default: ;
      endcase
      pending.push_back(o);
    endfunction

    function void check_result(logic [COEFW-1:0] result, logic [STW-1:0] status);
      outcome_t o;
      if (pending.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
        return;
      end
      o = pending.pop_front();
      if (result !== o.result) begin
        $error("result: expected %0d, actual %0d", $signed(o.result), $signed(result));
        errors++;
      end
      if (status !== o.status) begin
        $error("status: expected %0d, actual %0d", o.status, status);
        errors++;
      end
    endfunction
  endclass
endpackage

`default_nettype wire

[verif/sparse_polynomial_term_engine_tb.sv]
// ----------------------------------------------------------------------------
// Sparse polynomial term engine testbench
// Directed and random commands with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_polynomial_term_engine_tb;
  import spte_pkg::*;
  import spte_tb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  logic    clk_i;
  logic    rst_ni;
  longint  cycles;
  bit      long_hold;
  bit      sending_done;
  poly_book book;

  spte_in_if  cmd_ch ();
  spte_out_if res_ch ();

  sparse_polynomial_term_engine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_ch.sink),
    .out_o  (res_ch.source)
  );

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cmd_ch.valid = 0;
    cmd_ch.mode = '0;
    cmd_ch.slot = '0;
    cmd_ch.value = '0;
    cmd_ch.exponent = '0;
    cmd_ch.target_slot = '0;
    res_ch.ready = 0;
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("sparse_polynomial_term_engine verification failed");
      $finish;
    end
  end
  initial cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni && cmd_ch.valid && cmd_ch.ready)
      book.note_command(cmd_ch.mode, cmd_ch.slot, cmd_ch.value, cmd_ch.exponent,
                        cmd_ch.target_slot);
    if (rst_ni && res_ch.valid && res_ch.ready)
      book.check_result(res_ch.result, res_ch.status);
  end

  initial begin
    int k;
    long_hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      k++;
      if (long_hold) res_ch.ready <= 0;
      else if ((k / 300) % 3 == 0) res_ch.ready <= 1;
      else res_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  int gap_left;
  int burst_left;

  task automatic send(logic [MODEW-1:0] mode, logic [SLOTW-1:0] s, logic [COEFW-1:0] v,
                      logic [EXPW-1:0] e, logic [SLOTW-1:0] t);
    while (gap_left > 0) begin
      cmd_ch.valid <= 0;
      @(posedge clk_i);
      gap_left--;
    end
    cmd_ch.valid <= 1;
    cmd_ch.mode <= mode;
    cmd_ch.slot <= s;
    cmd_ch.value <= v;
    cmd_ch.exponent <= e;
    cmd_ch.target_slot <= t;
    do @(posedge clk_i); while (!cmd_ch.ready);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 80);
    end
  endtask

  function automatic logic [COEFW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 4) - 2;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [EXPW-1:0] pick_expo();
    case ($urandom_range(0, 3))
      0: return EXPW'($urandom_range(0, 6));
      1: return EXPW'($urandom_range(250, 255));
      default: return EXPW'($urandom());
    endcase
  endfunction

  initial begin
    logic [MODEW-1:0] mode;
    logic [SLOTW-1:0] s;
    book = new();
    sending_done = 0;
    gap_left = 0;
    burst_left = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    send(MODE_EVAL, 3, 5, 0, 0);
    send(MODE_ADD, 3, 1, 1, 0);
    send(MODE_SCALE, 3, 2, 0, 0);
    send(MODE_DIFF, 3, 0, 0, 1);
    send(MODE_CLEAR, 0, 0, 0, 0);
    send(MODE_EVAL, 0, 0, 0, 0);
    send(MODE_ADD, 0, 32'h7fff_ffff, 255, 0);
    send(MODE_ADD, 0, 32'h8000_0000, 0, 0);
    send(MODE_ADD, 0, 5, 0, 0);
    send(MODE_ADD, 0, 0, 9, 0);
    send(MODE_ADD, 0, 32'h8000_0001, 255, 0);
    send(MODE_ADD, 0, 3, 255, 0);
    send(MODE_EVAL, 0, 0, 0, 0);
    send(MODE_EVAL, 0, 32'hffff_ffff, 0, 0);
    send(MODE_DIFF, 0, 0, 0, 7);
    send(MODE_EVAL, 7, 2, 0, 0);
    send(MODE_DIFF, 7, 0, 0, 7);
    send(MODE_SCALE, 0, 32'h8000_0000, 0, 0);
    send(MODE_SCALE, 0, 0, 0, 0);
    for (int i = 0; i < 17; i++) send(MODE_ADD, 1, COEFW'(i + 1), EXPW'(i * 15), 0);
    send(3'd5, 1, 0, 0, 0);
    send(3'd7, 1, 32'hffff_ffff, 8'hff, 7);
    send(MODE_EVAL, 1, 3, 0, 0);
    // Hold the receiver off while commands keep arriving.
    long_hold = 1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        long_hold = 0;
      end
      begin
        for (int i = 0; i < 4; i++) send(MODE_EVAL, 1, COEFW'(i), 0, 0);
        send(MODE_EVAL, 1, 7, 0, 0);
      end
    join
    for (int n = 0; n < 920; n++) begin
      s = SLOTW'($urandom_range(0, 7));
      case ($urandom_range(0, 19))
        0, 1: mode = MODE_CLEAR;
        2, 3, 4, 5, 6, 7, 8, 9: mode = MODE_ADD;
        10, 11: mode = MODE_SCALE;
        12, 13, 14, 15: mode = MODE_EVAL;
        16, 17: mode = MODE_DIFF;
        default: mode = MODEW'($urandom_range(0, 7));
      endcase
      if (mode == MODE_ADD && $urandom_range(0, 2) != 0)
        send(mode, s, pick_value(), EXPW'($urandom_range(0, 20)), SLOTW'($urandom()));
      else send(mode, s, pick_value(), pick_expo(), SLOTW'($urandom()));
    end
    cmd_ch.valid <= 0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    while (book.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (book.errors == 0 && book.pending.size() == 0)
      $display("sparse_polynomial_term_engine verification clean");
    else
      $display("sparse_polynomial_term_engine verification failed");
    $finish;
  end
endmodule

`default_nettype wire
